// File: hw/rtl/shgb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash grid broadphase package
// Shared types and constants for the hash grid unit.
// ----------------------------------------------------------------------------
package shgb_pkg;

	localparam logic [31:0] HASH_PX = 32'd73856093;
	localparam logic [31:0] HASH_PY = 32'd19349663;

	typedef enum logic [1:0] {
		REQ_CLEAR = 2'd0,
		REQ_ADD   = 2'd1,
		REQ_FIND  = 2'd2,
		REQ_POINT = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OBJ_FULL = 2'd1,
		ST_KEY_FULL = 2'd2,
		ST_TOO_BIG  = 2'd3
	} status_t;

	// Request from the sequencer to the shared divider.
	typedef struct packed {
		logic        go;
		logic [20:0] num;
		logic [16:0] den;
	} div_req_t;

	// Divider answer.
	typedef struct packed {
		logic        done;
		logic [20:0] quo;
	} div_rsp_t;

endpackage

// File: hw/rtl/spatial_hash_grid_broadphase_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash grid broadphase unit
// Hash grid of object buckets with add, find, point query and clear.
// ----------------------------------------------------------------------------
// Usage: a request beat is taken when start is high and busy is low; busy
// then stays high until the last result of that request has been shown,
// but an add refused for a full object count is answered with busy low.
// Each result is shown for one cycle with strobe high; last marks the final
// result. The receiver cannot stall the block. The cell_size register is
// written over its own valid/ready channel (ready whenever busy is low).
// Clear sweeps the bucket fill memory. Add and find walk each lattice
// sample through a shared serial divider, two divides per sample, then a
// duplicate scan over the keys already gathered. Each distinct key is then
// looked up by a sequential search over NUM_KEYS slots; an add searches
// once to check and once to insert. Point query is one sample and one
// lookup. Find then scans the hit map one object index per cycle, with a
// result beat for each set bit, or one not-found beat if none is set.
// Reset: object count and key valid bits are reset directly; fill counts
// go to zero through a clearing pass over the NUM_KEYS slots; busy stays
// high during that pass.
// ----------------------------------------------------------------------------
module spatial_hash_grid_broadphase_unit #(
	parameter int MAX_OBJECTS  = 64,
	parameter int NUM_KEYS     = 256,
	parameter int BUCKET_DEPTH = 16,
	parameter int MAX_SPAN     = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic signed [19:0] center_x,
	input  logic signed [19:0] center_y,
	input  logic [15:0] radius,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [11:0] cfg_data,
	output logic        strobe,
	output logic [5:0]  object_index,
	output logic        found,
	output logic [1:0]  status,
	output logic        last
);
	import shgb_pkg::*;

	localparam int KW  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int BW  = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
	localparam int FW  = $clog2(BUCKET_DEPTH + 1);
	localparam int OW  = $clog2(MAX_OBJECTS + 1);
	localparam int SW  = $clog2(MAX_SPAN + 1);
	localparam int KBN = MAX_SPAN * MAX_SPAN;
	localparam int KBW = $clog2(KBN + 1);
	localparam int KBA = $clog2(KBN);
	localparam int KCW = $clog2(NUM_KEYS + 1);

	typedef enum logic [17:0] {
		S_INIT   = 18'h00001,
		S_IDLE   = 18'h00002,
		S_TIMES  = 18'h00004,
		S_DX     = 18'h00008,
		S_DY     = 18'h00010,
		S_HASH   = 18'h00020,
		S_DEDUP  = 18'h00040,
		S_CHECK  = 18'h00080,
		S_CHKRD  = 18'h00100,
		S_CHKEND = 18'h00200,
		S_INS    = 18'h00400,
		S_INSRD  = 18'h00800,
		S_INSWR  = 18'h01000,
		S_GATHER = 18'h02000,
		S_MEMRD  = 18'h04000,
		S_SCAN   = 18'h08000,
		S_POINT  = 18'h10000,
		S_EMIT   = 18'h20000
	} state_t;

	state_t state_q;

	// Request and configuration registers.
	logic [11:0] cell_q;
	logic [1:0]  req_q;
	logic signed [20:0] x_q, y_q;
	logic [15:0] rad_q;
	logic [16:0] d;
	assign d = {1'b0, ((cell_q == '0) ? 12'd1 : cell_q), 4'd0};

	// Storage.
	logic [31:0]       key_mem [NUM_KEYS];
	logic [FW-1:0]     fill_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] kvalid_q;
	logic [5:0]        mem_mem [NUM_KEYS << BW];
	logic [31:0]       kbuf_q [KBN];
	logic [KBW-1:0]    nk_q;
	logic [OW-1:0]     ocount_q;
	logic [KCW-1:0]    used_q;
	logic [MAX_OBJECTS-1:0] hit_q;

	// Sequencing registers.
	logic [SW-1:0]  ti_q, tj_q, times_q;
	logic [KBW-1:0] k_q;
	logic [KW-1:0]  s_q;
	logic [KCW-1:0] free_q, fresh_q;
	logic [BW:0]    m_q;
	logic [FW-1:0]  fill_rd_q;
	logic [20:0]    qx_q;
	logic [31:0]    key_q;
	logic [31:0]    key_rd_q;
	logic [31:0]    kb_rd_q;
	logic [5:0]     mem_rd_q;
	logic           dup_q;
	logic [6:0]     scan_q;
	logic           neg_q;
	logic           pend_q;
	logic [1:0]     phase_q;

	// Divider on magnitudes.
	div_req_t dreq;
	div_rsp_t drsp;
	shgb_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic signed [21:0] samp_x, samp_y;
	assign samp_x = 22'(x_q) + 22'(ti_q) * 22'(d) - 22'(rad_q);
	assign samp_y = 22'(y_q) + 22'(tj_q) * 22'(d) - 22'(rad_q);

	logic [20:0] mag_num;
	logic        mag_neg;
	always_comb begin
		mag_neg = 1'b0;
		mag_num = '0;
		if (state_q == S_TIMES) begin
			mag_num = {4'd0, rad_q, 1'b0};
		end else if (state_q == S_DX) begin
			mag_neg = samp_x[21];
			mag_num = mag_neg ? 21'(-samp_x) : samp_x[20:0];
		end else begin
			mag_neg = samp_y[21];
			mag_num = mag_neg ? 21'(-samp_y) : samp_y[20:0];
		end
	end

	assign dreq = '{go: !pend_q && (state_q == S_TIMES || state_q == S_DX ||
			state_q == S_DY),
		num: mag_num, den: d};

	logic [31:0] qsig;
	assign qsig = neg_q ? 32'(-{11'd0, drsp.quo}) : {11'd0, drsp.quo};

	// Result register.
	logic       out_v_q, out_f_q, out_l_q;
	logic [5:0] out_i_q;
	logic [1:0] out_s_q;
	assign strobe       = out_v_q;
	assign object_index = out_i_q;
	assign found        = out_f_q;
	assign status       = out_s_q;
	assign last         = out_l_q;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);

	logic bucket_full_rd;
	assign bucket_full_rd = (32'(fill_rd_q) >= 32'(BUCKET_DEPTH));

	// Memory ports.
	always_ff @(posedge clk) begin
		key_rd_q  <= key_mem[s_q];
		fill_rd_q <= fill_mem[s_q];
		mem_rd_q  <= mem_mem[{s_q, m_q[BW-1:0]}];
		kb_rd_q   <= kbuf_q[k_q[KBA-1:0]];
		if (state_q == S_INIT)
			fill_mem[s_q] <= '0;
		if (state_q == S_INSWR) begin
			if (!kvalid_q[s_q]) begin
				key_mem[s_q]  <= kb_rd_q;
				fill_mem[s_q] <= FW'(1);
				mem_mem[{s_q, {BW{1'b0}}}] <= 6'(ocount_q);
			end else begin
				fill_mem[s_q] <= fill_rd_q + FW'(1);
				mem_mem[{s_q, fill_rd_q[BW-1:0]}] <= 6'(ocount_q);
			end
		end
		if (state_q == S_HASH && !dup_q && nk_q < KBW'(KBN))
			kbuf_q[nk_q[KBA-1:0]] <= key_q;
	end

	logic slot_hit;
	assign slot_hit = kvalid_q[s_q] && key_rd_q == kb_rd_q;
	logic s_last;
	assign s_last = (32'(s_q) == NUM_KEYS - 1);

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			cell_q   <= 12'd48;
			kvalid_q <= '0;
			ocount_q <= '0;
			used_q   <= '0;
			hit_q    <= '0;
			out_v_q  <= 1'b0;
			s_q      <= '0;
			pend_q   <= 1'b0;
		end else begin
			out_v_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					s_q <= s_q + KW'(1);
					if (s_last) begin
						out_v_q <= pend_q;
						out_i_q <= '0; out_f_q <= 1'b0;
						out_s_q <= ST_OK; out_l_q <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_valid) cell_q <= cfg_data;
					if (start) begin
						req_q <= req_type;
						x_q <= 21'(center_x);
						y_q <= 21'(center_y);
						rad_q <= (req_t'(req_type) == REQ_POINT) ? '0 : radius;
						nk_q <= '0; ti_q <= '0; tj_q <= '0;
						s_q <= '0;
						hit_q <= '0;
						case (req_t'(req_type))
							REQ_CLEAR: begin
								kvalid_q <= '0; ocount_q <= '0; used_q <= '0;
								pend_q <= 1'b1; state_q <= S_INIT;
							end
							REQ_ADD: begin
								if (32'(ocount_q) >= MAX_OBJECTS) begin
									out_v_q <= 1'b1; out_i_q <= '0;
									out_f_q <= 1'b0; out_s_q <= ST_OBJ_FULL;
									out_l_q <= 1'b1;
								end else state_q <= S_TIMES;
							end
							REQ_FIND: state_q <= S_TIMES;
							default: begin
								times_q <= '0;
								state_q <= S_DX;
							end
						endcase
					end
				end
				S_TIMES: begin
					if (drsp.done) begin
						pend_q <= 1'b0;
						if (32'(drsp.quo) + 2 > MAX_SPAN) begin
							out_v_q <= 1'b1; out_i_q <= '0; out_f_q <= 1'b0;
							out_s_q <= ST_TOO_BIG; out_l_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							times_q <= SW'(drsp.quo + 21'd1);
							state_q <= S_DX;
						end
					end else pend_q <= 1'b1;
				end
				S_DX: begin
					if (!pend_q) begin neg_q <= mag_neg; pend_q <= 1'b1; end
					if (drsp.done) begin
						pend_q <= 1'b0;
						qx_q <= qsig[20:0];
						state_q <= S_DY;
					end
				end
				S_DY: begin
					if (!pend_q) begin neg_q <= mag_neg; pend_q <= 1'b1; end
					if (drsp.done) begin
						pend_q <= 1'b0;
						key_q <= ((qx_q[20] ? {11'h7FF, qx_q} : {11'd0, qx_q}) * HASH_PX)
							^ (qsig * HASH_PY);
						k_q <= '0; dup_q <= 1'b0; phase_q <= 2'd0;
						state_q <= S_DEDUP;
					end
				end
				// Compare the new key with the keys gathered so far, one a read.
				S_DEDUP: begin
					if (k_q == nk_q) state_q <= S_HASH;
					else if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						if (kb_rd_q == key_q) begin
							dup_q <= 1'b1; state_q <= S_HASH;
						end else k_q <= k_q + KBW'(1);
					end
				end
				S_HASH: begin
					if (!dup_q && nk_q < KBW'(KBN)) nk_q <= nk_q + KBW'(1);
					if (tj_q == times_q) begin
						tj_q <= '0;
						if (ti_q == times_q) begin
							k_q <= '0; s_q <= '0;
							fresh_q <= '0;
							phase_q <= 2'd0;
							free_q <= KCW'(NUM_KEYS) - used_q;
							if (req_t'(req_q) == REQ_ADD) state_q <= S_CHECK;
							else state_q <= S_GATHER;
						end else begin
							ti_q <= ti_q + SW'(1);
							state_q <= S_DX;
						end
					end else begin
						tj_q <= tj_q + SW'(1);
						state_q <= S_DX;
					end
				end
				// Add: look up each key; count fresh keys, reject full buckets.
				S_CHECK: begin
					if (k_q == nk_q) state_q <= S_CHKEND;
					else state_q <= S_CHKRD;
				end
				S_CHKRD: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						if (slot_hit) begin
							if (bucket_full_rd) begin
								out_v_q <= 1'b1; out_i_q <= '0; out_f_q <= 1'b0;
								out_s_q <= ST_KEY_FULL; out_l_q <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								k_q <= k_q + KBW'(1); s_q <= '0; state_q <= S_CHECK;
							end
						end else if (s_last) begin
							fresh_q <= fresh_q + KCW'(1);
							k_q <= k_q + KBW'(1); s_q <= '0; state_q <= S_CHECK;
						end else s_q <= s_q + KW'(1);
					end
				end
				S_CHKEND: begin
					if (fresh_q > free_q) begin
						out_v_q <= 1'b1; out_i_q <= '0; out_f_q <= 1'b0;
						out_s_q <= ST_KEY_FULL; out_l_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= '0; s_q <= '0; state_q <= S_INS;
					end
				end
				// Add: find the slot (or first free one) and append.
				S_INS: begin
					if (k_q == nk_q) begin
						out_v_q <= 1'b1; out_i_q <= 6'(ocount_q); out_f_q <= 1'b1;
						out_s_q <= ST_OK; out_l_q <= 1'b1;
						ocount_q <= ocount_q + OW'(1);
						state_q <= S_IDLE;
					end else state_q <= S_INSRD;
				end
				S_INSRD: begin
					if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						if (slot_hit) state_q <= S_INSWR;
						else if (s_last) begin
							s_q <= '0; state_q <= S_POINT;
						end else s_q <= s_q + KW'(1);
					end
				end
				S_INSWR: begin
					if (!kvalid_q[s_q]) begin
						kvalid_q[s_q] <= 1'b1;
						used_q <= used_q + KCW'(1);
					end
					k_q <= k_q + KBW'(1); s_q <= '0; state_q <= S_INS;
				end
				// Free slot search for a fresh key, reused state.
				S_POINT: begin
					if (!kvalid_q[s_q]) state_q <= S_INSWR;
					else if (s_last) begin
						k_q <= k_q + KBW'(1); s_q <= '0; state_q <= S_INS;
					end else s_q <= s_q + KW'(1);
				end
				// Find and point query: look up each key.
				S_GATHER: begin
					if (k_q == nk_q) begin
						if (req_t'(req_q) == REQ_FIND) begin
							scan_q <= '0; state_q <= S_SCAN;
						end else begin
							out_v_q <= 1'b1; out_i_q <= '0; out_f_q <= 1'b0;
							out_s_q <= ST_OK; out_l_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						if (slot_hit) begin
							m_q <= '0; state_q <= S_MEMRD;
						end else if (s_last) begin
							k_q <= k_q + KBW'(1); s_q <= '0;
						end else s_q <= s_q + KW'(1);
					end
				end
				S_MEMRD: begin
					if (32'(m_q) >= 32'(fill_rd_q) || 32'(m_q) >= BUCKET_DEPTH) begin
						k_q <= k_q + KBW'(1); s_q <= '0; state_q <= S_GATHER;
					end else if (phase_q == 2'd0) phase_q <= 2'd1;
					else begin
						phase_q <= 2'd0;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					m_q <= m_q + (BW+1)'(1);
					if (req_t'(req_q) == REQ_FIND) begin
						hit_q[mem_rd_q[$clog2(MAX_OBJECTS)-1:0]] <= 1'b1;
					end else begin
						out_v_q <= 1'b1; out_i_q <= mem_rd_q; out_f_q <= 1'b1;
						out_s_q <= ST_OK;
						out_l_q <= (32'(m_q) + 1 >= 32'(fill_rd_q))
							|| (32'(m_q) + 1 >= BUCKET_DEPTH);
					end
					if (req_t'(req_q) != REQ_FIND &&
					    ((32'(m_q) + 1 >= 32'(fill_rd_q)) || (32'(m_q) + 1 >= BUCKET_DEPTH)))
						state_q <= S_IDLE;
					else state_q <= S_MEMRD;
				end
				// Report hit map bits in ascending order.
				S_SCAN: begin
					if (32'(scan_q) == MAX_OBJECTS) begin
						if (hit_q == '0) begin
							out_v_q <= 1'b1; out_i_q <= '0; out_f_q <= 1'b0;
							out_s_q <= ST_OK; out_l_q <= 1'b1;
						end
						hit_q <= '0;
						state_q <= S_IDLE;
					end else begin
						if (hit_q[scan_q[$clog2(MAX_OBJECTS)-1:0]]) begin
							out_v_q <= 1'b1; out_i_q <= 6'(scan_q); out_f_q <= 1'b1;
							out_s_q <= ST_OK;
							out_l_q <= ((hit_q >> scan_q) >> 1) == '0;
						end
						scan_q <= scan_q + 7'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: hw/rtl/shgb_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit a cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module shgb_div (
	input  logic               clk,
	input  logic               arst_n,
	input  shgb_pkg::div_req_t req,
	output shgb_pkg::div_rsp_t rsp
);
	import shgb_pkg::*;

	logic [20:0] quo_q;
	logic [17:0] rem_q;
	logic [16:0] den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [17:0] trial;

	// One restoring step on the shifted remainder.
	assign trial = {rem_q[16:0], quo_q[20]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd21;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial;
				quo_q <= {quo_q[19:0], 1'b1};
			end else begin
				rem_q <= {rem_q[16:0], quo_q[20]};
				quo_q <= {quo_q[19:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quo: quo_q};

endmodule

// File: hw/rtl/shgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash grid port checker
// Port-level checks of the hash grid unit, bound to the top level.
// ----------------------------------------------------------------------------
module shgb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic       found,
	input logic [1:0] status,
	input logic       cfg_ready
);
	import shgb_pkg::*;

	// An accepted request makes the block busy or produces a result strobe.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || strobe) else $error("request not taken");

	// A found result always carries ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && found |-> status == ST_OK) else $error("found with error");

	// Configuration is only ready while idle.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy) else $error("cfg ready while busy");
endmodule

bind spatial_hash_grid_broadphase_unit shgb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .strobe(strobe),
	.found(found), .status(status), .cfg_ready(cfg_ready)
);
